// ===== hw/rtl/tsp_nearest_neighbour_two_opt_defines.svh =====
// Shared assertion macros; every use samples on clk and is muted while rst_n is low.
`ifndef TSP_NEAREST_NEIGHBOUR_TWO_OPT_DEFINES_SVH
`define TSP_NEAREST_NEIGHBOUR_TWO_OPT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define TSPNN_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tspnn check failed");

// Consequent must hold in the cycle after the antecedent
`define TSPNN_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tspnn check failed");

`endif

// ===== hw/rtl/tspnn_pkg.sv =====
package tspnn_pkg;

    localparam int MAX_POINTS  = 64;
    localparam int MAX_DIM     = 4;
    localparam int COORD_WIDTH = 16;

    // fixed field widths
    localparam int IN_COORD_W  = 16;
    localparam int IDX_W       = 6;
    localparam int CFG_W       = 3;
    localparam int CFG_ADDR_W  = 1;
    localparam int S_TDATA_W   = 16;
    localparam int S_TUSER_W   = 1;
    localparam int M_TDATA_W   = 8;
    localparam int M_TUSER_W   = 2;

    // derived widths
    localparam int PT_W    = $clog2(MAX_POINTS);
    localparam int PC_W    = $clog2(MAX_POINTS + 1);
    localparam int DIM_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DCNT_W  = $clog2(MAX_DIM + 1);
    localparam int CADDR_W = $clog2(MAX_POINTS * MAX_DIM);
    localparam int SQ_W    = 2 * (COORD_WIDTH + 1);
    localparam int DIST_W  = SQ_W + DCNT_W;
    localparam int SUM_W   = DIST_W + 1;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_DIMS    = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_IMPROVE = 1'b1;

    // item kinds
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_START = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE,
        S_INIT,
        S_B_RDI,
        S_B_GETI,
        S_B_RDJ,
        S_B_GETJ,
        S_B_DWAIT,
        S_B_SW1,
        S_B_SW2,
        S_I_RD,
        S_I_GET,
        S_I_DST,
        S_I_DWAIT,
        S_I_CMP,
        S_I_NEXT,
        S_F_CHK,
        S_F_RDL,
        S_F_RDH,
        S_F_WL,
        S_F_WH,
        S_E_RD,
        S_E_LD,
        S_EMPTY
    } state_t;

    typedef struct packed {
        logic                          we;
        logic [CADDR_W-1:0]            addr;
        logic signed [COORD_WIDTH-1:0] data;
    } coord_wr_t;

    typedef struct packed {
        logic              start;
        logic [PT_W-1:0]   pt_a;
        logic [PT_W-1:0]   pt_b;
        logic [DCNT_W-1:0] dims;
    } dist_req_t;

    typedef struct packed {
        logic              done;
        logic [DIST_W-1:0] value;
    } dist_rsp_t;

    // clamp an incoming component to the stored width
    function automatic logic signed [COORD_WIDTH-1:0] sat_coord(
        input logic signed [IN_COORD_W-1:0] v);
        int x;
        int lim;
        lim = (2 ** (COORD_WIDTH - 1)) - 1;
        x   = int'(v);
        if (x > lim) x = lim;
        if (x < -lim - 1) x = -lim - 1;
        return COORD_WIDTH'(x);
    endfunction

    // dims register mapped into 1..MAX_DIM
    function automatic logic [DCNT_W-1:0] eff_dims(input logic [CFG_W-1:0] cfg);
        int d;
        d = int'(cfg);
        if (d < 1) d = 1;
        if (d > MAX_DIM) d = MAX_DIM;
        return DCNT_W'(d);
    endfunction

    function automatic logic [CADDR_W-1:0] caddr(input logic [PT_W-1:0] pt,
                                                 input logic [DIM_W-1:0] k);
        return CADDR_W'(int'(pt) * MAX_DIM + int'(k));
    endfunction

endpackage

// ===== hw/rtl/tsp_nearest_neighbour_two_opt.sv =====
// Tour builder: nearest-neighbour tour from point 0, then an optional 2-opt pass.
// Input channel s_*: s_tuser[0] is the kind (0 load one component, 1 start),
// s_tdata holds the signed component. Loads are taken one per cycle while idle.
// Output channel m_*: one beat per tour position, m_tdata[5:0] point index,
// m_tlast on the final position, m_tuser = {empty_set, overflow}.
// A start with no complete point gives a single beat with empty_set and last set.
// Configuration: cfg_we/cfg_addr/cfg_wdata, index 0 dims_used, 1 improve_enable.
// A start for n points uses one shared distance unit for every squared
// distance of the greedy build and of the 2-opt pass; each 2-opt reversal
// swaps the segment pair by pair. Emission reads each tour position and
// loads it as a beat once the output register is free. The tour store has
// one read port, which sets the read and swap steps. s_tready is low from
// start until the last beat is loaded into the output register.
// When m_tready is low the current beat holds and the sequencer waits.
// Reset clears point count, overflow flag and the output valid flag and sets
// dims_used to 2 and improve_enable to 1; stored coordinates are not cleared.
module tsp_nearest_neighbour_two_opt (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [tspnn_pkg::S_TDATA_W-1:0]   s_tdata,   // coord
    input  logic [tspnn_pkg::S_TUSER_W-1:0]   s_tuser,   // op
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [tspnn_pkg::M_TDATA_W-1:0]   m_tdata,   // point_index, zero pad
    output logic                              m_tlast,
    output logic [tspnn_pkg::M_TUSER_W-1:0]   m_tuser,   // {empty_set, overflow}
    input  logic                              cfg_we,
    input  logic [tspnn_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [tspnn_pkg::CFG_W-1:0]       cfg_wdata
);
    `include "tsp_nearest_neighbour_two_opt_defines.svh"
    import tspnn_pkg::*;

    state_t state_reg;
    state_t state_next;

    logic [CFG_W-1:0]  dims_cfg_reg;
    logic              improve_reg;
    logic [PC_W-1:0]   pc_reg;
    logic [DIM_W-1:0]  cc_reg;
    logic              ovf_reg;
    logic [PC_W-1:0]   n_reg;
    logic              run_ovf_reg;
    logic [DCNT_W-1:0] dims;

    logic [PT_W-1:0]   i_reg;
    logic [PT_W-1:0]   j_reg;
    logic [PT_W-1:0]   k_reg;
    logic [PT_W-1:0]   lo_reg;
    logic [PT_W-1:0]   hi_reg;
    logic [1:0]        q_reg;
    logic [1:0]        dq_reg;
    logic [PT_W-1:0]   ti_reg;
    logic [PT_W-1:0]   tj_reg;
    logic [PT_W-1:0]   first_pt_reg;
    logic [PT_W-1:0]   best_pt_reg;
    logic [PT_W-1:0]   best_pos_reg;
    logic [DIST_W-1:0] best_reg;
    logic [PT_W-1:0]   pi_reg;
    logic [PT_W-1:0]   ci_reg;
    logic [PT_W-1:0]   pj_reg;
    logic [PT_W-1:0]   cj_reg;
    logic [SUM_W-1:0]  before_reg;
    logic [SUM_W-1:0]  after_reg;
    logic [PT_W-1:0]   vlo_reg;

    logic [PT_W-1:0]   tour_mem [MAX_POINTS];
    logic [PT_W-1:0]   t_rdata_reg;
    logic [PT_W-1:0]   t_raddr;
    logic              t_we;
    logic [PT_W-1:0]   t_waddr;
    logic [PT_W-1:0]   t_wdata;

    logic              out_valid_reg;
    logic [IDX_W-1:0]  out_idx_reg;
    logic              out_last_reg;
    logic              out_ovf_reg;
    logic              out_empty_reg;
    logic              out_free;
    logic              out_load;

    coord_wr_t         cwr;
    dist_req_t         dreq;
    dist_rsp_t         drsp;

    logic              in_acc;
    logic              ld_acc;
    logic              st_acc;
    logic [PT_W-1:0]   n_m1;
    logic              j_last;
    logic              i_more;
    logic [DCNT_W-1:0] cc_inc;

    assign dims     = eff_dims(dims_cfg_reg);
    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign ld_acc   = in_acc && (s_tuser[0] == OP_LOAD);
    assign st_acc   = in_acc && (s_tuser[0] == OP_START);
    assign n_m1     = PT_W'(n_reg - PC_W'(1));
    assign j_last   = (j_reg == n_m1);
    assign i_more   = (PC_W'(i_reg) + PC_W'(2)) < n_reg;
    assign out_free = !out_valid_reg || m_tready;
    assign cc_inc   = DCNT_W'(cc_reg) + DCNT_W'(1);

    // coordinate write for a load beat that fits
    always_comb
    begin
        cwr.we   = ld_acc && (pc_reg < PC_W'(MAX_POINTS));
        cwr.addr = caddr(PT_W'(pc_reg), cc_reg);
        cwr.data = sat_coord(s_tdata);
    end

    tspnn_dist_unit u_dist (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (cwr),
        .req   (dreq),
        .rsp   (drsp)
    );

    // tour store: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (t_we)
        begin
            tour_mem[t_waddr] <= t_wdata;
        end
        t_rdata_reg <= tour_mem[t_raddr];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (st_acc)
                begin
                    state_next = (pc_reg == '0) ? S_EMPTY : S_INIT;
                end
            end
            S_INIT:
            begin
                if (k_reg == n_m1)
                begin
                    state_next = (n_reg < PC_W'(2)) ? S_E_RD : S_B_RDI;
                end
            end
            S_B_RDI:   state_next = S_B_GETI;
            S_B_GETI:  state_next = S_B_RDJ;
            S_B_RDJ:   state_next = S_B_GETJ;
            S_B_GETJ:  state_next = S_B_DWAIT;
            S_B_DWAIT:
            begin
                if (drsp.done)
                begin
                    state_next = j_last ? S_B_SW1 : S_B_RDJ;
                end
            end
            S_B_SW1:   state_next = S_B_SW2;
            S_B_SW2:
            begin
                if (i_more)
                begin
                    state_next = S_B_RDI;
                end
                else
                begin
                    state_next = improve_reg ? S_I_RD : S_E_RD;
                end
            end
            S_I_RD:    state_next = S_I_GET;
            S_I_GET:   state_next = (q_reg == 2'd3) ? S_I_DST : S_I_RD;
            S_I_DST:   state_next = S_I_DWAIT;
            S_I_DWAIT:
            begin
                if (drsp.done)
                begin
                    state_next = (dq_reg == 2'd3) ? S_I_CMP : S_I_DST;
                end
            end
            S_I_CMP:   state_next = (after_reg < before_reg) ? S_F_CHK : S_I_NEXT;
            S_F_CHK:   state_next = (lo_reg < hi_reg) ? S_F_RDL : S_I_NEXT;
            S_F_RDL:   state_next = S_F_RDH;
            S_F_RDH:   state_next = S_F_WL;
            S_F_WL:    state_next = S_F_WH;
            S_F_WH:    state_next = S_F_CHK;
            S_I_NEXT:
            begin
                if (j_last && !i_more)
                begin
                    state_next = S_E_RD;
                end
                else
                begin
                    state_next = S_I_RD;
                end
            end
            S_E_RD:    state_next = S_E_LD;
            S_E_LD:
            begin
                if (out_free)
                begin
                    state_next = (k_reg == n_m1) ? S_IDLE : S_E_RD;
                end
            end
            S_EMPTY:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    // memory, distance and output controls
    always_comb
    begin
        t_raddr    = k_reg;
        t_we       = 1'b0;
        t_waddr    = k_reg;
        t_wdata    = k_reg;
        dreq.start = 1'b0;
        dreq.pt_a  = ti_reg;
        dreq.pt_b  = t_rdata_reg;
        dreq.dims  = dims;
        out_load   = 1'b0;
        case (state_reg)
            S_INIT:
            begin
                t_we = 1'b1;
            end
            S_B_RDI:   t_raddr = i_reg;
            S_B_RDJ:   t_raddr = j_reg;
            S_B_GETJ:  dreq.start = 1'b1;
            S_B_SW1:
            begin
                t_we    = 1'b1;
                t_waddr = i_reg + PT_W'(1);
                t_wdata = best_pt_reg;
            end
            S_B_SW2:
            begin
                t_we    = 1'b1;
                t_waddr = best_pos_reg;
                t_wdata = first_pt_reg;
            end
            S_I_RD:
            begin
                case (q_reg)
                    2'd0:    t_raddr = (i_reg == '0) ? n_m1 : i_reg - PT_W'(1);
                    2'd1:    t_raddr = i_reg;
                    2'd2:    t_raddr = j_reg - PT_W'(1);
                    default: t_raddr = j_reg;
                endcase
            end
            S_I_DST:
            begin
                dreq.start = 1'b1;
                case (dq_reg)
                    2'd0:
                    begin
                        dreq.pt_a = pi_reg;
                        dreq.pt_b = ci_reg;
                    end
                    2'd1:
                    begin
                        dreq.pt_a = pj_reg;
                        dreq.pt_b = cj_reg;
                    end
                    2'd2:
                    begin
                        dreq.pt_a = pi_reg;
                        dreq.pt_b = pj_reg;
                    end
                    default:
                    begin
                        dreq.pt_a = ci_reg;
                        dreq.pt_b = cj_reg;
                    end
                endcase
            end
            S_F_RDL:   t_raddr = lo_reg;
            S_F_RDH:   t_raddr = hi_reg;
            S_F_WL:
            begin
                t_we    = 1'b1;
                t_waddr = lo_reg;
                t_wdata = t_rdata_reg;
            end
            S_F_WH:
            begin
                t_we    = 1'b1;
                t_waddr = hi_reg;
                t_wdata = vlo_reg;
            end
            S_E_LD:    out_load = out_free;
            S_EMPTY:   out_load = out_free;
            default:
            begin
                t_we = 1'b0;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            dims_cfg_reg  <= CFG_W'(2);
            improve_reg   <= 1'b1;
            pc_reg        <= '0;
            cc_reg        <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_DIMS:    dims_cfg_reg <= cfg_wdata;
                    REG_IMPROVE: improve_reg  <= cfg_wdata[0];
                    default:     improve_reg  <= improve_reg;
                endcase
            end
            // loading and clearing at start
            if (st_acc)
            begin
                pc_reg  <= '0;
                cc_reg  <= '0;
                ovf_reg <= 1'b0;
            end
            else if (ld_acc)
            begin
                if (pc_reg >= PC_W'(MAX_POINTS))
                begin
                    ovf_reg <= 1'b1;
                end
                else if (cc_inc >= dims)
                begin
                    cc_reg <= '0;
                    pc_reg <= pc_reg + PC_W'(1);
                end
                else
                begin
                    cc_reg <= cc_reg + DIM_W'(1);
                end
            end
            // output register
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // sequencer datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                n_reg       <= pc_reg;
                run_ovf_reg <= ovf_reg;
                k_reg       <= '0;
                i_reg       <= '0;
            end
            S_INIT:
            begin
                k_reg <= (k_reg == n_m1) ? '0 : k_reg + PT_W'(1);
                i_reg <= '0;
            end
            S_B_GETI:
            begin
                ti_reg <= t_rdata_reg;
                j_reg  <= i_reg + PT_W'(1);
            end
            S_B_GETJ:  tj_reg <= t_rdata_reg;
            S_B_DWAIT:
            begin
                if (drsp.done)
                begin
                    if ((j_reg == i_reg + PT_W'(1)) || (drsp.value < best_reg))
                    begin
                        best_reg     <= drsp.value;
                        best_pos_reg <= j_reg;
                        best_pt_reg  <= tj_reg;
                    end
                    if (j_reg == i_reg + PT_W'(1))
                    begin
                        first_pt_reg <= tj_reg;
                    end
                    j_reg <= j_reg + PT_W'(1);
                end
            end
            S_B_SW2:
            begin
                if (i_more)
                begin
                    i_reg <= i_reg + PT_W'(1);
                end
                else
                begin
                    i_reg <= '0;
                    j_reg <= PT_W'(1);
                    q_reg <= '0;
                    k_reg <= '0;
                end
            end
            S_I_GET:
            begin
                case (q_reg)
                    2'd0:    pi_reg <= t_rdata_reg;
                    2'd1:    ci_reg <= t_rdata_reg;
                    2'd2:    pj_reg <= t_rdata_reg;
                    default: cj_reg <= t_rdata_reg;
                endcase
                q_reg  <= q_reg + 2'd1;
                dq_reg <= '0;
            end
            S_I_DWAIT:
            begin
                if (drsp.done)
                begin
                    case (dq_reg)
                        2'd0:    before_reg <= SUM_W'(drsp.value);
                        2'd1:    before_reg <= before_reg + SUM_W'(drsp.value);
                        2'd2:    after_reg  <= SUM_W'(drsp.value);
                        default: after_reg  <= after_reg + SUM_W'(drsp.value);
                    endcase
                    dq_reg <= dq_reg + 2'd1;
                end
            end
            S_I_CMP:
            begin
                lo_reg <= i_reg;
                hi_reg <= j_reg - PT_W'(1);
            end
            S_F_RDH:   vlo_reg <= t_rdata_reg;
            S_F_WH:
            begin
                lo_reg <= lo_reg + PT_W'(1);
                hi_reg <= hi_reg - PT_W'(1);
            end
            S_I_NEXT:
            begin
                q_reg <= '0;
                k_reg <= '0;
                if (j_last)
                begin
                    i_reg <= i_reg + PT_W'(1);
                    j_reg <= i_reg + PT_W'(2);
                end
                else
                begin
                    j_reg <= j_reg + PT_W'(1);
                end
            end
            S_E_LD:
            begin
                if (out_free)
                begin
                    k_reg <= k_reg + PT_W'(1);
                end
            end
            default:
            begin
                k_reg <= k_reg;
            end
        endcase
        // output beat payload
        if (out_load)
        begin
            out_ovf_reg <= run_ovf_reg;
            if (state_reg == S_EMPTY)
            begin
                out_idx_reg   <= '0;
                out_last_reg  <= 1'b1;
                out_empty_reg <= 1'b1;
            end
            else
            begin
                out_idx_reg   <= IDX_W'(t_rdata_reg);
                out_last_reg  <= (k_reg == n_m1);
                out_empty_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(out_idx_reg);
    assign m_tlast  = out_last_reg;
    assign m_tuser  = {out_empty_reg, out_ovf_reg};

    `TSPNN_ASSERT_NOW(a_empty_is_last, m_tvalid && m_tuser[1], m_tlast)
    `TSPNN_ASSERT_NOW(a_dist_from_seq, dreq.start, state_reg == S_B_GETJ || state_reg == S_I_DST)
    `TSPNN_ASSERT_NEXT(a_start_clears, st_acc, pc_reg == '0 && !ovf_reg)
endmodule

// ===== hw/rtl/tspnn_dist_unit.sv =====
`include "tsp_nearest_neighbour_two_opt_defines.svh"

// Squared distance between two stored points, one component per cycle.
module tspnn_dist_unit (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tspnn_pkg::coord_wr_t  wr,
    input  tspnn_pkg::dist_req_t  req,
    output tspnn_pkg::dist_rsp_t  rsp
);
    import tspnn_pkg::*;

    logic signed [COORD_WIDTH-1:0] mem [MAX_POINTS*MAX_DIM];
    logic signed [COORD_WIDTH-1:0] ra_reg;
    logic signed [COORD_WIDTH-1:0] rb_reg;
    logic signed [COORD_WIDTH:0]   diff;
    logic signed [SQ_W-1:0]        sq;
    logic [SQ_W-1:0]               prod_reg;
    logic [DIST_W-1:0]             acc_reg;
    logic [PT_W-1:0]               a_reg;
    logic [PT_W-1:0]               b_reg;
    logic [DIM_W-1:0]              k_reg;
    logic [DIM_W-1:0]              dims_m1_reg;
    logic                          busy_reg;
    logic                          issue_reg;
    logic                          v1_reg;
    logic                          l1_reg;
    logic                          v2_reg;
    logic                          l2_reg;
    logic                          done_reg;
    logic [CADDR_W-1:0]            addr_a;
    logic [CADDR_W-1:0]            addr_b;

    assign addr_a = caddr(a_reg, k_reg);
    assign addr_b = caddr(b_reg, k_reg);

    // coordinate store: one write, two registered reads
    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
        ra_reg <= mem[addr_a];
        rb_reg <= mem[addr_b];
    end

    // difference and square at full width
    assign diff = {ra_reg[COORD_WIDTH-1], ra_reg} - {rb_reg[COORD_WIDTH-1], rb_reg};
    assign sq   = diff * diff;

    always_ff @(posedge clk)
    begin
        prod_reg <= $unsigned(sq);
        if (req.start)
        begin
            a_reg       <= req.pt_a;
            b_reg       <= req.pt_b;
            dims_m1_reg <= DIM_W'(req.dims - DCNT_W'(1));
            acc_reg     <= '0;
        end
        else if (v2_reg)
        begin
            acc_reg <= acc_reg + DIST_W'(prod_reg);
        end
    end

    // component sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            issue_reg <= 1'b0;
            k_reg     <= '0;
            v1_reg    <= 1'b0;
            l1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            l2_reg    <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            v1_reg   <= issue_reg;
            l1_reg   <= issue_reg && (k_reg == dims_m1_reg);
            v2_reg   <= v1_reg;
            l2_reg   <= l1_reg;
            done_reg <= v2_reg && l2_reg;
            if (req.start)
            begin
                busy_reg  <= 1'b1;
                issue_reg <= 1'b1;
                k_reg     <= '0;
            end
            else
            begin
                if (issue_reg)
                begin
                    k_reg <= k_reg + DIM_W'(1);
                    if (k_reg == dims_m1_reg)
                    begin
                        issue_reg <= 1'b0;
                    end
                end
                if (v2_reg && l2_reg)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign rsp.done  = done_reg;
    assign rsp.value = acc_reg;

    `TSPNN_ASSERT_NOW(a_start_when_idle, req.start, !busy_reg)
    `TSPNN_ASSERT_NEXT(a_done_single, done_reg, !done_reg)
    `TSPNN_ASSERT_NOW(a_done_after_busy, done_reg, !issue_reg)
endmodule

// ===== test/tb_tsp_nearest_neighbour_two_opt.sv =====
`timescale 1ns / 100ps

module tb_tsp_nearest_neighbour_two_opt;
    import tspnn_pkg::*;

    // one tour position as it should appear on the output
    typedef struct {
        logic [IDX_W-1:0] point_index;
        logic             last;
        logic             overflow;
        logic             empty_set;
    } tour_beat_t;

    // tour predictor and queue of expected tour beats
    class tour_scoreboard;
        longint             coord_mem [MAX_POINTS*MAX_DIM];
        int                 order [MAX_POINTS];
        int                 n_points;
        int                 n_comps;
        bit                 ovf;
        int                 dims_reg;
        bit                 improve_on;
        tour_beat_t         pending [$];
        int                 mismatches;

        function void reset_state();
            n_points   = 0;
            n_comps    = 0;
            ovf        = 0;
            dims_reg   = 2;
            improve_on = 1;
            mismatches = 0;
        endfunction

        function void set_reg(int addr, int val);
            if (addr == REG_DIMS)
                dims_reg = val & 7;
            else
                improve_on = val[0];
        endfunction

        function int dims_eff();
            if (dims_reg < 1) return 1;
            if (dims_reg > MAX_DIM) return MAX_DIM;
            return dims_reg;
        endfunction

        function longint unsigned sqdist(int a, int b, int d);
            longint unsigned s;
            longint          df;
            s = 0;
            for (int k = 0; k < d; k++)
            begin
                df = coord_mem[a*MAX_DIM+k] - coord_mem[b*MAX_DIM+k];
                s += df * df;
            end
            return s;
        endfunction

        function void reverse_seg(int lo, int hi_excl);
            int hi;
            int t;
            if (hi_excl == 0) return;
            hi = hi_excl - 1;
            while (lo < hi)
            begin
                t = order[lo]; order[lo] = order[hi]; order[hi] = t;
                lo++; hi--;
            end
        endfunction

        // greedy tour from point 0, earliest candidate wins a tie
        function void nearest_tour(int n, int d);
            int              bp;
            int              t;
            longint unsigned best;
            longint unsigned v;
            for (int i = 0; i < n; i++) order[i] = i;
            for (int i = 0; i + 1 < n; i++)
            begin
                bp   = i + 1;
                best = sqdist(order[i], order[i+1], d);
                for (int j = i + 2; j < n; j++)
                begin
                    v = sqdist(order[i], order[j], d);
                    if (v < best)
                    begin
                        best = v;
                        bp   = j;
                    end
                end
                t = order[i+1]; order[i+1] = order[bp]; order[bp] = t;
            end
        endfunction

        // single segment-reversal pass, endpoints re-read each step
        function void two_opt(int n, int d);
            int              pi, ci, pj, cj;
            longint unsigned old_len, new_len;
            for (int i = 0; i < n; i++)
                for (int j = i + 1; j < n; j++)
                begin
                    pi = order[(i + n - 1) % n];
                    ci = order[i];
                    pj = order[j-1];
                    cj = order[j];
                    old_len = sqdist(pi, ci, d) + sqdist(pj, cj, d);
                    new_len = sqdist(pi, pj, d) + sqdist(ci, cj, d);
                    if (new_len < old_len) reverse_seg(i, j);
                end
        endfunction

        function void note_input(logic op, logic signed [15:0] c);
            tour_beat_t b;
            int         d;
            d = dims_eff();
            if (op == OP_LOAD)
            begin
                if (n_points >= MAX_POINTS)
                begin
                    ovf = 1;
                    return;
                end
                coord_mem[n_points*MAX_DIM+n_comps] = longint'(c);
                n_comps++;
                if (n_comps >= d)
                begin
                    n_comps = 0;
                    n_points++;
                end
                return;
            end
            if (n_points == 0)
            begin
                b.point_index = '0;
                b.last        = 1;
                b.overflow    = ovf;
                b.empty_set   = 1;
                pending.push_back(b);
            end
            else
            begin
                nearest_tour(n_points, d);
                if (improve_on) two_opt(n_points, d);
                for (int k = 0; k < n_points; k++)
                begin
                    b.point_index = order[k];
                    b.last        = (k + 1 == n_points);
                    b.overflow    = ovf;
                    b.empty_set   = 0;
                    pending.push_back(b);
                end
            end
            n_points = 0;
            n_comps  = 0;
            ovf      = 0;
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] data, logic lst,
                                   logic [M_TUSER_W-1:0] user);
            tour_beat_t e;
            bit         bad;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: idx=%0d last=%0b user=%b", data, lst, user);
                return;
            end
            e   = pending.pop_front();
            bad = (data != M_TDATA_W'(e.point_index)) || (lst != e.last)
                  || (user[0] != e.overflow) || (user[1] != e.empty_set);
            if (bad)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp idx=%0d last=%0b ovf=%0b empty=%0b, got tdata=%0d last=%0b user=%b",
                             e.point_index, e.last, e.overflow, e.empty_set, data, lst, user);
            end
        endfunction
    endclass

    localparam int STALL_LIMIT = 2000000;

    logic                   clk = 0;
    logic                   rst_n = 0;
    logic                   s_tvalid = 0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic [S_TUSER_W-1:0]   s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tlast;
    logic [M_TUSER_W-1:0]   m_tuser;
    logic                   cfg_we = 0;
    logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
    logic [CFG_W-1:0]       cfg_wdata = '0;

    tour_scoreboard sb = new();
    int             burst_left = 0;
    bit             hold_req = 0;
    int             idle_cycles = 0;

    tsp_nearest_neighbour_two_opt u_top (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    always #5 clk = ~clk;

    // receiver: random stall pattern, one long hold-off once a beat is waiting
    always @(negedge clk)
    begin : rx_stall
        int hold_cnt;
        if (hold_req && m_tvalid)
        begin
            hold_req = 0;
            hold_cnt = 400;
        end
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            m_tready <= 0;
        end
        else if (($time / 2000) % 3 == 0)
            m_tready <= 1;
        else
            m_tready <= ($urandom_range(0, 3) != 0);
    end

    // output check on every accepted beat
    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tlast, m_tuser);

    // watchdog on cycles with no beat moving
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_beat(logic op, logic [15:0] c);
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                s_tvalid <= 0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        s_tvalid <= 1;
        s_tuser  <= op;
        s_tdata  <= c;
        do @(posedge clk); while (!s_tready);
        sb.note_input(op, c);
        burst_left--;
        @(negedge clk);
    endtask

    // wait for every expected beat, then let the block settle
    task automatic drain();
        s_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, int val);
        cfg_we    <= 1;
        cfg_addr  <= addr;
        cfg_wdata <= CFG_W'(val);
        sb.set_reg(addr, val);
        @(negedge clk);
        cfg_we <= 0;
    endtask

    function automatic logic [15:0] pick_coord(int mode);
        case (mode)
            0: return 16'($signed($urandom_range(0, 4)) - 2);
            1: return 16'($urandom);
            default:
                case ($urandom_range(0, 3))
                    0: return 16'h7fff;
                    1: return 16'h8000;
                    2: return 16'h0000;
                    default: return 16'hffff;
                endcase
        endcase
    endfunction

    // load a set, optionally a partial point, then start; collect the tour
    // unless the next set is to be offered while this one is still running
    task automatic run_set(int npts, int partial, int mode, bit wait_out = 1);
        int d;
        d = sb.dims_eff();
        for (int p = 0; p < npts; p++)
            for (int k = 0; k < d; k++)
                send_beat(OP_LOAD, pick_coord(mode));
        for (int k = 0; k < partial; k++)
            send_beat(OP_LOAD, pick_coord(mode));
        send_beat(OP_START, 16'($urandom));
        if (wait_out)
            drain();
    endtask

    initial
    begin
        sb.reset_state();
        repeat (6) @(negedge clk);
        rst_n <= 1;
        @(negedge clk);

        // directed: empty start, extremes, ties with a dropped partial point
        run_set(0, 0, 0);
        run_set(3, 0, 2);
        write_reg(REG_DIMS, 1);
        write_reg(REG_IMPROVE, 0);
        run_set(4, 0, 0);
        write_reg(REG_DIMS, 4);
        write_reg(REG_IMPROVE, 1);
        run_set(3, 3, 2);

        // capacity: 64 points plus dropped components, long receiver hold-off
        // while the next set is already being offered
        write_reg(REG_DIMS, 0);
        hold_req = 1;
        run_set(MAX_POINTS, 2, 1, 0);
        run_set(2, 1, 1);
        write_reg(REG_DIMS, 7);
        run_set(2, 1, 1);

        // random sets with random settings
        for (int ph = 0; ph < 2; ph++)
        begin
            write_reg(REG_DIMS, $urandom_range(0, 7));
            write_reg(REG_IMPROVE, $urandom_range(0, 1));
            run_set($urandom_range(0, 4), $urandom_range(0, 1), $urandom_range(0, 2));
        end

        repeat (50) @(negedge clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
